FILE: design/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sfs_pkg;

    // Storage limits
    localparam int MAX_FRAMES = 256;
    localparam int POS_W      = 8;    // frame index width
    localparam int EC_W       = 9;    // effective frame count, up to MAX_FRAMES
    localparam int SPAN_W     = 9;    // ping-pong cycle length, up to 2*(MAX_FRAMES-1)
    localparam int PERIOD_W   = 24;
    localparam int ELAPSED_W  = 20;
    localparam int ACC_W      = 25;   // accumulator never exceeds period plus one tick
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Divider geometry: ACC_W quotient bits, one per cycle
    localparam int DIV_W      = ACC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100000);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_FORWARD = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_PINGPONG = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_FRAME_PERIOD = 2'd1,
        CFG_LOOP_MODE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t                  operation;
        logic [ELAPSED_W-1:0] elapsed_us;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] frame_index;
        logic             done_res;
        logic             halted;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec_simple;
        logic accumulate;
        logic start_div_n;
        logic take_n;
        logic start_div_m;
        logic take_r;
        logic apply;
        logic load_out;
    } sfs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic runnable;
        logic acc_gt;
        logic div_done;
        logic need_mod;
        logic out_free;
    } sfs_status_t;

endpackage

`default_nettype wire

FILE: design/sfs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg for widths.
`default_nettype none

module sfs_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [sfs_pkg::DIV_W-1:0]    dividend,
    input  wire logic [sfs_pkg::PERIOD_W-1:0] divisor,
    output logic                              done,
    output logic [sfs_pkg::DIV_W-1:0]         quotient,
    output logic [sfs_pkg::PERIOD_W-1:0]      remainder
);
    import sfs_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [PERIOD_W-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [PERIOD_W:0]    trial;
    logic                 fits;
    logic [PERIOD_W:0]    trial_sub;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        trial_sub = trial - {1'b0, dsr_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/sfs_ctrl.sv
// Controller state machine for the sprite frame sequencer.
// Depends on sfs_pkg for the command and status structs.
`default_nettype none

module sfs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire sfs_pkg::sfs_status_t status,
    output sfs_pkg::sfs_cmd_t         cmd
);
    import sfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_DIV_N,
        S_MOD,
        S_DIV_M,
        S_APPLY,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.op != OP_TICK)
                begin
                    cmd.exec_simple = 1'b1;
                    state_next      = S_EMIT;
                end
                else if (status.runnable)
                begin
                    cmd.accumulate = 1'b1;
                    state_next     = S_CHECK;
                end
                else
                    state_next = S_EMIT;
            end
            S_CHECK:
            begin
                if (status.acc_gt)
                begin
                    cmd.start_div_n = 1'b1;
                    state_next      = S_DIV_N;
                end
                else
                    state_next = S_EMIT;
            end
            S_DIV_N:
            begin
                if (status.div_done)
                begin
                    cmd.take_n = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (status.need_mod)
                begin
                    cmd.start_div_m = 1'b1;
                    state_next      = S_DIV_M;
                end
                else
                    state_next = S_APPLY;
            end
            S_DIV_M:
            begin
                if (status.div_done)
                begin
                    cmd.take_r = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign item_stall = stall_reg;

endmodule

`default_nettype wire

FILE: design/sfs_datapath.sv
// Datapath: configuration, animation state, step count and frame update.
// Depends on sfs_pkg and instantiates sfs_div.
`default_nettype none

module sfs_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire sfs_pkg::item_t                 item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output sfs_pkg::result_t                    result,
    input  wire sfs_pkg::sfs_cmd_t              cmd,
    output sfs_pkg::sfs_status_t                status
);
    import sfs_pkg::*;

    // Configuration
    logic [EC_W-1:0]     frame_count_reg;
    logic [PERIOD_W-1:0] frame_period_reg;
    mode_t               mode_reg;

    // Animation state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             bounce_reg, bounce_next;
    logic             finished_reg, finished_next;
    logic             pause_reg, pause_next;

    // Working registers
    item_t            item_reg;
    logic [DIV_W-1:0] n_reg;
    logic [SPAN_W-1:0] r_reg;
    result_t          result_reg;
    logic             result_valid_reg;

    // Derived values
    logic [EC_W-1:0]     ec;
    logic [POS_W-1:0]    last;
    logic [SPAN_W-1:0]   span;
    logic [PERIOD_W-1:0] period;

    // Divider
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [PERIOD_W-1:0] div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [PERIOD_W-1:0] div_rem;

    // Frame update temporaries
    logic [POS_W-1:0]  avail;
    logic [EC_W-1:0]   fwd_sum;
    logic [EC_W:0]     rev_sum;
    logic [SPAN_W-1:0] pp_c0;
    logic [SPAN_W:0]   pp_c1;
    logic [SPAN_W-1:0] pp_c;
    logic [SPAN_W-1:0] pp_mirror;

    // Effective count saturates, zero period behaves as one microsecond
    always_comb
    begin
        ec     = (frame_count_reg > EC_W'(MAX_FRAMES)) ? EC_W'(MAX_FRAMES) : frame_count_reg;
        last   = POS_W'(ec - EC_W'(1));
        span   = {last, 1'b0};
        period = (frame_period_reg == '0) ? PERIOD_W'(1) : frame_period_reg;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= EC_W'(1);
            frame_period_reg <= PERIOD_RESET;
            mode_reg         <= MODE_NONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_COUNT:  frame_count_reg  <= cfg_data[EC_W-1:0];
                CFG_FRAME_PERIOD: frame_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LOOP_MODE:    mode_reg         <= mode_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    // Shared divider: period steps first, then the step count folded onto the loop
    assign div_start    = cmd.start_div_n | cmd.start_div_m;
    assign div_dividend = cmd.start_div_n ? (acc_reg - ACC_W'(1)) : n_reg;
    assign div_divisor  = cmd.start_div_n ? period
                        : PERIOD_W'((mode_reg == MODE_PINGPONG) ? span : SPAN_W'(ec));

    sfs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Frame update arithmetic
    always_comb
    begin
        avail   = last - pos_reg;
        fwd_sum = EC_W'(pos_reg) + r_reg;
        if (fwd_sum >= ec)
            fwd_sum = fwd_sum - ec;
        rev_sum = (EC_W+1)'(pos_reg) + (EC_W+1)'(ec) - (EC_W+1)'(r_reg);
        if (rev_sum >= (EC_W+1)'(ec))
            rev_sum = rev_sum - (EC_W+1)'(ec);
        if (!bounce_reg)
            pp_c0 = SPAN_W'(pos_reg);
        else if (pos_reg == '0)
            pp_c0 = '0;
        else
            pp_c0 = span - SPAN_W'(pos_reg);
        pp_c1 = (SPAN_W+1)'(pp_c0) + (SPAN_W+1)'(r_reg);
        if (pp_c1 >= (SPAN_W+1)'(span))
            pp_c1 = pp_c1 - (SPAN_W+1)'(span);
        pp_c      = pp_c1[SPAN_W-1:0];
        pp_mirror = span - pp_c;
    end

    // Next animation state
    always_comb
    begin
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        bounce_next   = bounce_reg;
        finished_next = finished_reg;
        pause_next    = pause_reg;

        if (cmd.exec_simple)
        begin
            case (item_reg.operation)
                OP_START: pause_next = 1'b0;
                OP_STOP:  pause_next = 1'b1;
                OP_RESTART:
                begin
                    pos_next      = (mode_reg == MODE_REVERSE && ec != '0) ? last : '0;
                    acc_next      = '0;
                    bounce_next   = 1'b0;
                    finished_next = 1'b0;
                end
                default: ;
            endcase
        end

        // Clamp a stale index, then add the elapsed time
        if (cmd.accumulate)
        begin
            if (EC_W'(pos_reg) >= ec)
                pos_next = last;
            acc_next = acc_reg + ACC_W'(item_reg.elapsed_us);
        end

        // Left over time is remainder plus one
        if (cmd.take_n)
            acc_next = ACC_W'(div_rem) + ACC_W'(1);

        if (cmd.apply)
        begin
            case (mode_reg)
                MODE_NONE:
                begin
                    if (n_reg > DIV_W'(avail))
                    begin
                        finished_next = 1'b1;
                        pos_next      = last;
                        acc_next      = '0;
                    end
                    else
                        pos_next = pos_reg + n_reg[POS_W-1:0];
                end
                MODE_FORWARD: pos_next = fwd_sum[POS_W-1:0];
                MODE_REVERSE: pos_next = rev_sum[POS_W-1:0];
                MODE_PINGPONG:
                begin
                    if (ec == EC_W'(1))
                    begin
                        pos_next    = '0;
                        bounce_next = bounce_reg ^ n_reg[0];
                    end
                    else if (pp_c == '0)
                    begin
                        pos_next    = '0;
                        bounce_next = 1'b1;
                    end
                    else if (EC_W'(pp_c) < ec)
                    begin
                        pos_next    = pp_c[POS_W-1:0];
                        bounce_next = 1'b0;
                    end
                    else
                    begin
                        pos_next    = pp_mirror[POS_W-1:0];
                        bounce_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Animation state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            acc_reg      <= '0;
            bounce_reg   <= 1'b0;
            finished_reg <= 1'b0;
            pause_reg    <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            bounce_reg   <= bounce_next;
            finished_reg <= finished_next;
            pause_reg    <= pause_next;
        end
    end

    // Item and step count payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= item;
        if (cmd.take_n)
            n_reg <= div_quo;
        if (cmd.take_r)
            r_reg <= div_rem[SPAN_W-1:0];
        if (cmd.load_out)
        begin
            result_reg.frame_index <= pos_reg;
            result_reg.done_res    <= finished_reg;
            result_reg.halted      <= pause_reg;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.load_out)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Status to controller
    always_comb
    begin
        status.op       = item_reg.operation;
        status.runnable = !pause_reg && !finished_reg && (ec != '0);
        status.acc_gt   = (acc_reg > ACC_W'(period));
        status.div_done = div_done;
        status.need_mod = (mode_reg != MODE_NONE)
                       && !(mode_reg == MODE_PINGPONG && ec == EC_W'(1));
        status.out_free = !result_valid_reg || !result_stall;
    end

endmodule

`default_nettype wire

FILE: design/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: controller plus datapath.
// Depends on sfs_pkg, sfs_ctrl, sfs_datapath.
//
// One result beat per input beat; items are taken one at a time. Each
// item passes through the controller states as follows:
// - Start, stop, restart, and a tick that is paused, finished or has no
//   frames, go from decode straight to emit.
// - A tick that stays within one period goes through decode, check, emit.
// - A tick that passes the period runs the shared restoring divider once
//   for the step count: 25 quotient bits, one per cycle. In forward,
//   reverse and multi-frame ping-pong the divider runs a second time to
//   fold the count onto the loop length. In no-loop mode and single-frame
//   ping-pong it runs once.
// Any number of frame steps costs the same. The result sits in an output
// register, so the next item is taken while a result still waits. A
// result that is still stalled when the following one is ready holds that
// item, and the input stays stalled until the output register frees.
// Configuration writes are taken in any cycle and must only be made while
// the block is idle.
`default_nettype none

module sprite_frame_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire sfs_pkg::item_t                 item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output sfs_pkg::result_t                    result
);
    import sfs_pkg::*;

    sfs_cmd_t    cmd;
    sfs_status_t status;

    sfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    sfs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

FILE: design/sfs_checker.sv
// Port-level checks for the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg for the beat types.
`default_nettype none

module sfs_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire sfs_pkg::item_t   item,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire sfs_pkg::result_t result
);
    import sfs_pkg::*;

    // A held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // One item at a time: the input stalls right after a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after accepting a beat");

    // A new result only appears when an item was in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared with no item in flight");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

`default_nettype wire
